// ----- hdl/bcs_pkg.sv -----
// Shared codes for the Bezier curve subdivider: mode codes and result half codes.
// No dependencies; imported by the top level and the output register.
package bcs_pkg;

   localparam int MODE_BITS = 2;

   localparam logic [MODE_BITS-1:0] MODE_CUBIC_T   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_CUBIC_MID = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_QUAD_T    = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_QUAD_MID  = 2'd3;

   localparam logic HALF_LEFT  = 1'b0;
   localparam logic HALF_RIGHT = 1'b1;

endpackage

// ----- hdl/bcs_lerp.sv -----
// Two-stage pipelined linear interpolation a + ((t*(b-a) + half) >> T_FRAC_BITS).
// Stands alone; instantiated by the top level for every de Casteljau lane.
module bcs_lerp #(
   parameter int COORD_BITS  = 32,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         adv,
   input  logic        [T_FRAC_BITS:0]  t,
   input  logic signed [COORD_BITS-1:0] a,
   input  logic signed [COORD_BITS-1:0] b,
   output logic signed [COORD_BITS-1:0] y
);

   localparam int PW = COORD_BITS + T_FRAC_BITS + 3;
   localparam logic signed [PW-1:0] RND = PW'(1) << (T_FRAC_BITS - 1);

   logic signed [COORD_BITS:0]    diff;
   logic signed [T_FRAC_BITS+1:0] t_s;
   logic signed [PW-1:0]          prod_in;
   logic signed [PW-1:0]          prod_ff;
   logic signed [COORD_BITS-1:0]  a_ff;
   logic signed [PW-1:0]          shifted;
   logic signed [COORD_BITS-1:0]  y_in;
   logic signed [COORD_BITS-1:0]  y_ff;

   assign diff    = $signed({b[COORD_BITS-1], b}) - $signed({a[COORD_BITS-1], a});
   assign t_s     = $signed({1'b0, t});
   assign prod_in = diff * t_s;

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         a_ff    <= a;
      end
   end

   // result is a convex combination, so wrapping the add is exact
   assign shifted = (prod_ff + RND) >>> T_FRAC_BITS;
   assign y_in    = a_ff + $signed(shifted[COORD_BITS-1:0]);

   always_ff @(posedge clock) begin
      if (adv) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule

// ----- hdl/bcs_out_ser.sv -----
// Output register: holds both sub-curves of one item and sends left then right.
// Depends on bcs_pkg for the half codes.
module bcs_out_ser
   import bcs_pkg::*;
#(
   parameter int DATA_BITS = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic [DATA_BITS-1:0] left_data,
   input  logic [DATA_BITS-1:0] right_data,
   output logic                 free,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DATA_BITS-1:0] rsp_tdata,
   output logic                 rsp_tuser,
   output logic                 rsp_tlast
);

   logic                 vld_ff;
   logic                 vld_in;
   logic                 half_ff;
   logic                 half_in;
   logic [DATA_BITS-1:0] left_ff;
   logic [DATA_BITS-1:0] right_ff;

   // free once empty, or as the right half leaves
   assign free = !vld_ff || (half_ff == HALF_RIGHT && rsp_tready);

   always_comb begin
      vld_in  = vld_ff;
      half_in = half_ff;
      if (load) begin
         vld_in  = 1'b1;
         half_in = HALF_LEFT;
      end else if (vld_ff && rsp_tready) begin
         if (half_ff == HALF_LEFT) begin
            half_in = HALF_RIGHT;
         end else begin
            vld_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= 1'b0;
         half_ff <= HALF_LEFT;
      end else begin
         vld_ff  <= vld_in;
         half_ff <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         left_ff  <= left_data;
         right_ff <= right_data;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = (half_ff == HALF_RIGHT) ? right_ff : left_ff;
   assign rsp_tuser  = half_ff;
   assign rsp_tlast  = (half_ff == HALF_RIGHT);

endmodule

// ----- hdl/bezier_curve_subdivider.sv -----
// Bezier curve subdivider top level: input stage, three de Casteljau levels, output register.
// Depends on bcs_pkg, bcs_lerp and bcs_out_ser.
//
//  channel | dir | handshake           | payload
//  req     | in  | req_tvalid/tready   | tuser: mode; tdata: split_t, start, controls, end
//  rsp     | out | rsp_tvalid/tready   | tuser: half; tlast: right half; tdata: sub-curve
//
// Seven register stages: one input stage, then two per interpolation level (multiply, round).
// Each item gives two beats, so the output register sets the sustained rate; the pipeline
// takes new items while earlier ones are still in flight.
// Reset clears only the valid bits and the output half flag. When the last stage holds an item
// that the output register cannot take, the whole pipeline holds, bubbles included.
module bezier_curve_subdivider
   import bcs_pkg::*;
#(
   parameter int COORD_BITS  = 32,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [MODE_BITS-1:0]     req_tuser,  // mode
   // split_t, start_px, start_py, first_cx, first_cy, second_cx, second_cy, end_px, end_py
   input  logic [((T_FRAC_BITS + 1 + 8 * COORD_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic                     rsp_tuser,  // half
   output logic                     rsp_tlast,
   // out_start_x, out_start_y, out_first_cx, out_first_cy, out_second_cx, out_second_cy,
   // out_end_x, out_end_y
   output logic [((8 * COORD_BITS + 7) / 8) * 8 - 1:0] rsp_tdata
);

   localparam int TW       = T_FRAC_BITS + 1;
   localparam int C        = COORD_BITS;
   localparam int PTS_BITS = 8 * C;
   localparam int RSP_BITS = ((PTS_BITS + 7) / 8) * 8;
   localparam int NST      = 7;
   localparam logic [TW-1:0] T_ONE  = TW'(1) << T_FRAC_BITS;
   localparam logic [TW-1:0] T_HALF = TW'(1) << (T_FRAC_BITS - 1);

   logic                adv;
   logic                ser_free;
   logic [NST-1:0]      vld_ff;
   logic [NST-1:0]      vld_in;

   logic [TW-1:0]       split_t;
   logic [TW-1:0]       t_in;
   logic                quad_in;
   logic [PTS_BITS-1:0] pts_in;
   logic [PTS_BITS-1:0] pts_ff;

   logic [TW-1:0]       t_ff    [1:4];
   logic [TW-1:0]       t0_ff;
   logic                quad_ff [0:6];
   logic [4*C-1:0]      ends_ff [1:6];
   logic [6*C-1:0]      l1      ;
   logic [6*C-1:0]      l1d_ff  [3:6];
   logic [4*C-1:0]      l2      ;
   logic [4*C-1:0]      l2d_ff  [5:6];
   logic [2*C-1:0]      l3      ;

   logic [PTS_BITS-1:0] left_data;
   logic [PTS_BITS-1:0] right_data;

   assign adv        = ser_free || !vld_ff[NST-1];
   assign req_tready = adv;

   assign vld_in = {vld_ff[NST-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // resolve t and map a quadratic onto the cubic lanes with its second control at the end point
   assign split_t = req_tdata[TW-1:0];

   always_comb begin
      if (req_tuser == MODE_CUBIC_MID || req_tuser == MODE_QUAD_MID) begin
         t_in = T_HALF;
      end else if (split_t > T_ONE) begin
         t_in = T_ONE;
      end else begin
         t_in = split_t;
      end
      quad_in = (req_tuser == MODE_QUAD_T || req_tuser == MODE_QUAD_MID);
      pts_in  = req_tdata[TW +: PTS_BITS];
      if (quad_in) begin
         pts_in[4*C +: 2*C] = req_tdata[TW + 6*C +: 2*C];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pts_ff     <= pts_in;
         t0_ff      <= t_in;
         quad_ff[0] <= quad_in;
         t_ff[1]    <= t0_ff;
         ends_ff[1] <= {pts_ff[6*C +: 2*C], pts_ff[0 +: 2*C]};
         for (int i = 1; i < 4; i++) begin
            t_ff[i+1] <= t_ff[i];
         end
         for (int i = 1; i < 7; i++) begin
            quad_ff[i] <= quad_ff[i-1];
         end
         for (int i = 2; i < 7; i++) begin
            ends_ff[i] <= ends_ff[i-1];
         end
         l1d_ff[3] <= l1;
         for (int i = 4; i < 7; i++) begin
            l1d_ff[i] <= l1d_ff[i-1];
         end
         l2d_ff[5] <= l2;
         l2d_ff[6] <= l2d_ff[5];
      end
   end

   // level one: p01, p12, p23 (x and y interleaved)
   for (genvar i = 0; i < 6; i++) begin : g_lvl1
      bcs_lerp #(
         .COORD_BITS  (COORD_BITS),
         .T_FRAC_BITS (T_FRAC_BITS)
      ) u_lerp (
         .clock (clock),
         .adv   (adv),
         .t     (t0_ff),
         .a     (pts_ff[i*C +: C]),
         .b     (pts_ff[(i+2)*C +: C]),
         .y     (l1[i*C +: C])
      );
   end

   // level two: q0, q1
   for (genvar i = 0; i < 4; i++) begin : g_lvl2
      bcs_lerp #(
         .COORD_BITS  (COORD_BITS),
         .T_FRAC_BITS (T_FRAC_BITS)
      ) u_lerp (
         .clock (clock),
         .adv   (adv),
         .t     (t_ff[2]),
         .a     (l1[i*C +: C]),
         .b     (l1[(i+2)*C +: C]),
         .y     (l2[i*C +: C])
      );
   end

   // level three: split point of the cubic
   for (genvar i = 0; i < 2; i++) begin : g_lvl3
      bcs_lerp #(
         .COORD_BITS  (COORD_BITS),
         .T_FRAC_BITS (T_FRAC_BITS)
      ) u_lerp (
         .clock (clock),
         .adv   (adv),
         .t     (t_ff[4]),
         .a     (l2[i*C +: C]),
         .b     (l2[(i+2)*C +: C]),
         .y     (l3[i*C +: C])
      );
   end

   always_comb begin
      if (quad_ff[6]) begin
         left_data  = {l2d_ff[6][0 +: 2*C], {(2*C){1'b0}},
                       l1d_ff[6][0 +: 2*C], ends_ff[6][0 +: 2*C]};
         right_data = {ends_ff[6][2*C +: 2*C], {(2*C){1'b0}},
                       l1d_ff[6][2*C +: 2*C], l2d_ff[6][0 +: 2*C]};
      end else begin
         left_data  = {l3, l2d_ff[6][0 +: 2*C],
                       l1d_ff[6][0 +: 2*C], ends_ff[6][0 +: 2*C]};
         right_data = {ends_ff[6][2*C +: 2*C], l1d_ff[6][4*C +: 2*C],
                       l2d_ff[6][2*C +: 2*C], l3};
      end
   end

   logic [RSP_BITS-1:0] left_pad;
   logic [RSP_BITS-1:0] right_pad;

   assign left_pad  = RSP_BITS'(left_data);
   assign right_pad = RSP_BITS'(right_data);

   bcs_out_ser #(
      .DATA_BITS (RSP_BITS)
   ) u_out_ser (
      .clock      (clock),
      .reset      (reset),
      .load       (adv && vld_ff[NST-1]),
      .left_data  (left_pad),
      .right_data (right_pad),
      .free       (ser_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- test/tb.sv -----
// Self-checking bench for bezier_curve_subdivider: directed and random curves in all four modes.
// Needs bcs_pkg and the subdivider RTL; a built-in de Casteljau predictor supplies the
// expected left and right halves.
module tb
   import bcs_pkg::*;
();

   localparam int REQ_W = 280;   // 17-bit split_t + eight 32-bit points, padded to bytes
   localparam int RSP_W = 256;
   localparam longint T_ONE  = 64'd65536;
   localparam longint T_HALF = 64'd32768;

   // points: 0 start x, 1 start y, 2 first cx, 3 first cy, 4 second cx, 5 second cy,
   // 6 end x, 7 end y
   typedef struct packed {
      logic [MODE_BITS-1:0] mode;
      logic [16:0]          split_t;
      logic [7:0][31:0]     pt;
   } curve_type;

   typedef struct packed {
      logic             half;
      logic             last;
      logic [7:0][31:0] pt;
   } sub_curve_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [MODE_BITS-1:0] req_tuser = '0;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic             rsp_tuser;
   logic             rsp_tlast;
   logic [RSP_W-1:0] rsp_tdata;

   curve_type     curves_pending[$];
   sub_curve_type halves_due[$];
   int            mismatches = 0;

   bezier_curve_subdivider u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] lerp_q(logic [31:0] a, logic [31:0] b, longint t);
      longint sa;
      longint sb;
      longint r;
      sa = longint'(signed'(a));
      sb = longint'(signed'(b));
      r = sa + ((t * (sb - sa) + T_HALF) >>> 16);
      return r[31:0];
   endfunction

   // Work out both halves of one curve and queue them, left first.
   task automatic predict_split(curve_type c);
      longint     t;
      logic [31:0] p01x, p01y, p12x, p12y, p23x, p23y, q0x, q0y, q1x, q1y, mx, my;
      sub_curve_type lh;
      sub_curve_type rh;
      t = (longint'(c.split_t) > T_ONE) ? T_ONE : longint'(c.split_t);
      if (c.mode == MODE_CUBIC_MID || c.mode == MODE_QUAD_MID) t = T_HALF;
      lh.half = HALF_LEFT;
      lh.last = 1'b0;
      rh.half = HALF_RIGHT;
      rh.last = 1'b1;
      p01x = lerp_q(c.pt[0], c.pt[2], t);
      p01y = lerp_q(c.pt[1], c.pt[3], t);
      if (c.mode == MODE_CUBIC_T || c.mode == MODE_CUBIC_MID) begin
         p12x = lerp_q(c.pt[2], c.pt[4], t);
         p12y = lerp_q(c.pt[3], c.pt[5], t);
         p23x = lerp_q(c.pt[4], c.pt[6], t);
         p23y = lerp_q(c.pt[5], c.pt[7], t);
         q0x = lerp_q(p01x, p12x, t);
         q0y = lerp_q(p01y, p12y, t);
         q1x = lerp_q(p12x, p23x, t);
         q1y = lerp_q(p12y, p23y, t);
         mx = lerp_q(q0x, q1x, t);
         my = lerp_q(q0y, q1y, t);
         lh.pt = {my, mx, q0y, q0x, p01y, p01x, c.pt[1], c.pt[0]};
         rh.pt = {c.pt[7], c.pt[6], p23y, p23x, q1y, q1x, my, mx};
      end else begin
         p12x = lerp_q(c.pt[2], c.pt[6], t);
         p12y = lerp_q(c.pt[3], c.pt[7], t);
         mx = lerp_q(p01x, p12x, t);
         my = lerp_q(p01y, p12y, t);
         lh.pt = {my, mx, 32'd0, 32'd0, p01y, p01x, c.pt[1], c.pt[0]};
         rh.pt = {c.pt[7], c.pt[6], 32'd0, 32'd0, p12y, p12x, my, mx};
      end
      halves_due.push_back(lh);
      halves_due.push_back(rh);
   endtask

   task automatic add_curve(logic [1:0] mode, logic [16:0] t,
                            logic [31:0] sx, logic [31:0] sy, logic [31:0] ax,
                            logic [31:0] ay, logic [31:0] bx, logic [31:0] by,
                            logic [31:0] ex, logic [31:0] ey);
      curve_type c;
      c.mode = mode;
      c.split_t = t;
      c.pt = {ey, ex, by, bx, ay, ax, sy, sx};
      curves_pending.push_back(c);
   endtask

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'($urandom_range(0, 3)) - 32'd1;
         3, 4: return 32'($urandom_range(0, 8191)) - 32'd4096;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [16:0] pick_t();
      logic [16:0] corner[6];
      corner = '{17'd0, 17'd1, 17'd32768, 17'd65535, 17'd65536, 17'h1ffff};
      case ($urandom_range(0, 7))
         0, 1: return corner[$urandom_range(0, 5)];
         2: return 17'($urandom_range(0, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   // Sender: bursts of random length separated by random gaps.
   int        burst_left = 0;
   int        gap_left = 0;
   curve_type in_flight;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_split(in_flight);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (curves_pending.size() != 0) begin
               in_flight = curves_pending.pop_front();
               req_tuser <= in_flight.mode;
               req_tdata <= {7'd0, in_flight.pt, in_flight.split_t};
               req_tvalid <= 1'b1;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left = burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: switch between free flow, coin-toss, sparse and long stall patterns.
   int stall_style = 0;
   int style_left = 0;
   int tick = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         tick = tick + 1;
         if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left = $urandom_range(20, 200);
         end else begin
            style_left = style_left - 1;
         end
         case (stall_style)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= (tick % 5) != 0;
            default: rsp_tready <= (tick % 16) < 3;
         endcase
      end
   end

   task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatches = mismatches + 1;
      if (mismatches <= 10)
         $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin : check_halves
      sub_curve_type got;
      sub_curve_type want;
      string         pt_name[8];
      pt_name = '{"start_x", "start_y", "first_cx", "first_cy",
                  "second_cx", "second_cy", "end_x", "end_y"};
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.half = rsp_tuser;
         got.last = rsp_tlast;
         got.pt = rsp_tdata;
         if (halves_due.size() == 0) begin
            note_mismatch("unexpected result, half", 32'd0, 32'(got.half));
         end else begin
            want = halves_due.pop_front();
            if (got.half !== want.half) note_mismatch("half", 32'(want.half), 32'(got.half));
            if (got.last !== want.last) note_mismatch("last", 32'(want.last), 32'(got.last));
            for (int i = 0; i < 8; i++)
               if (got.pt[i] !== want.pt[i]) note_mismatch(pt_name[i], want.pt[i], got.pt[i]);
         end
      end
   end

   initial begin : stimulus
      logic [31:0] mn;
      logic [31:0] mx;
      mn = 32'h8000_0000;
      mx = 32'h7fff_ffff;
      // t at zero, one, half and above one, across the four modes, mostly across the full coordinate span
      add_curve(MODE_CUBIC_T, 17'd0, mn, mx, mx, mn, mn, mx, mx, mn);
      add_curve(MODE_CUBIC_T, 17'd65536, mn, mx, mx, mn, mn, mx, mx, mn);
      add_curve(MODE_CUBIC_T, 17'h1ffff, mx, mn, mn, mx, mx, mn, mn, mx);
      add_curve(MODE_CUBIC_T, 17'd65537, 32'd5, 32'd7, 32'd100, 32'd200, 32'd300, 32'd1,
                32'd9, 32'd11);
      add_curve(MODE_CUBIC_T, 17'd1, mn, mn, mx, mx, mn, mn, mx, mx);
      add_curve(MODE_CUBIC_T, 17'd65535, mn, mn, mx, mx, mn, mn, mx, mx);
      add_curve(MODE_CUBIC_MID, 17'h1ffff, mn, mx, mx, mn, mn, mx, mx, mn);
      add_curve(MODE_CUBIC_MID, 17'd0, 32'd0, 32'd0, 32'd1, 32'hffff_ffff, 32'd2,
                32'hffff_fffe, 32'd3, 32'hffff_fffd);
      add_curve(MODE_QUAD_T, 17'd0, mn, mx, mx, mn, 32'h1234_5678, 32'h9abc_def0, mx, mn);
      add_curve(MODE_QUAD_T, 17'd65536, mx, mn, mn, mx, 32'hdead_beef, 32'h0bad_f00d, mn, mx);
      add_curve(MODE_QUAD_T, 17'h1ffff, mn, mn, mx, mx, mx, mx, mn, mn);
      add_curve(MODE_QUAD_T, 17'd32768, 32'd0, 32'd0, 32'd1, 32'hffff_ffff, mx, mn,
                32'd1, 32'hffff_ffff);
      add_curve(MODE_QUAD_MID, 17'd12345, mn, mx, mx, mn, mx, mx, mn, mx);
      add_curve(MODE_QUAD_MID, 17'h1ffff, 32'd0, 32'd0, 32'd3, 32'hffff_fffd,
                32'hffff_ffff, 32'hffff_ffff, 32'd1, 32'hffff_ffff);
      // rounding exactly at one half, both signs of the difference
      add_curve(MODE_CUBIC_T, 17'd32768, 32'd0, 32'd1, 32'd1, 32'd0, 32'd0, 32'd1,
                32'd1, 32'd0);
      add_curve(MODE_CUBIC_T, 17'd16384, 32'd0, 32'd2, 32'd2, 32'd0, 32'd0, 32'd2,
                32'd2, 32'd0);
      // degenerate curves
      add_curve(MODE_CUBIC_T, 17'd40000, mx, mx, mx, mx, mx, mx, mx, mx);
      add_curve(MODE_QUAD_T, 17'd40000, mn, mn, mn, mn, mn, mn, mn, mn);
      add_curve(MODE_CUBIC_T, 17'd21845, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                32'd0, 32'd0);
      for (int n = 0; n < 1500; n++)
         add_curve(2'($urandom_range(0, 3)), pick_t(), pick_coord(), pick_coord(),
                   pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                   pick_coord(), pick_coord());

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (curves_pending.size() != 0 || req_tvalid) @(posedge clock);
      while (halves_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && halves_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/bcs_pkg.sv
hdl/bcs_lerp.sv
hdl/bcs_out_ser.sv
hdl/bezier_curve_subdivider.sv
test/tb.sv
